/* hw/rtl/c3rso_pkg.sv */
// ---------------------------------------------------------------------------
// c3rso_pkg
// shared types and constants of the 3x3 rgb convolution block
// ---------------------------------------------------------------------------
package c3rso_pkg;

    localparam int LINE_MAX  = 4096;
    localparam int ADDR_W    = $clog2(LINE_MAX);
    localparam int MAX16     = 32768;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd7;

    typedef struct packed {
        logic [15:0] pix_red;
        logic [15:0] pix_green;
        logic [15:0] pix_blue;
        logic [15:0] pix_alpha;
        logic        frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] res_red;
        logic [15:0] res_green;
        logic [15:0] res_blue;
        logic [15:0] res_alpha;
        logic        write_pixel;
        logic        row_end;
    } out_beat_t;

    // packed pixel: alpha, blue, green, red from msb to lsb
    typedef logic [63:0] pixel_t;

    typedef struct packed {
        logic [23:0]        coef_top;
        logic [23:0]        coef_mid;
        logic [23:0]        coef_bot;
        logic signed [23:0] scale;
        logic signed [16:0] offset;
        logic               gray;
        logic               deep;
        logic [12:0]        width;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic take;      // capture input beat, issue line-store read
        logic win;       // read data valid: shift window, write stores
        logic mac;       // start channel sum
        logic fin;       // scale and clamp
        logic out_load;  // load output register
    } dp_cmd_t;

    function automatic logic [15:0] trunc_mask(input logic [15:0] v, input logic deep);
        trunc_mask = deep ? v : {8'd0, v[7:0]};
    endfunction

endpackage

/* hw/rtl/c3rso_ram.sv */
// ---------------------------------------------------------------------------
// c3rso_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module c3rso_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hw/rtl/c3rso_ctrl.sv */
// ---------------------------------------------------------------------------
// c3rso_ctrl
// sequencer: accept, read stores, window, sum, scale, output hand-off
// ---------------------------------------------------------------------------
module c3rso_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                emit,
    input  logic                out_full,
    input  logic                out_taken,
    output c3rso_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MAC, ST_FIN, ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   out_free;

    assign out_free = !out_full || out_taken;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.win    = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (emit)
                begin
                    cmd.mac    = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> state_reg == ST_READ)
        else $error("take did not move to read");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output overwritten");
    a_mac_after_win: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac |-> $past(cmd.win))
        else $error("sum started without window");
`endif

endmodule

/* hw/rtl/c3rso_dp.sv */
// ---------------------------------------------------------------------------
// c3rso_dp
// line stores, window, weighted sums, scale, clamp, gray, output register
// ---------------------------------------------------------------------------
module c3rso_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  c3rso_pkg::cfg_t     cfg,
    input  c3rso_pkg::in_beat_t in_beat,
    input  c3rso_pkg::dp_cmd_t  cmd,
    output logic                emit,
    output logic                out_full,
    input  logic                out_taken,
    output c3rso_pkg::out_beat_t out_beat
);

    localparam int AW = c3rso_pkg::ADDR_W;

    c3rso_pkg::pixel_t pix_reg;
    c3rso_pkg::pixel_t win_reg [6];
    c3rso_pkg::pixel_t col_reg [3][3];
    c3rso_pkg::pixel_t up_rd, mid_rd;
    logic [AW-1:0]     col_cnt_reg;
    logic [12:0]       row_cnt_reg;
    logic [AW-1:0]     c_reg;
    logic [12:0]       r_reg;
    logic [12:0]       width_eff;
    logic              last_reg;
    logic              emit_reg;
    logic              fs;
    logic [AW-1:0]     c_now;
    logic [12:0]       r_now;
    logic              last_now;

    // window sums
    logic signed [27:0] sum_reg [3];
    logic signed [51:0] prod_reg [3];
    logic [15:0]        res_c [3];
    logic [15:0]        gray_c;

    always_comb
    begin
        if (cfg.width < 13'd3)
        begin
            width_eff = 13'd3;
        end
        else if (cfg.width > 13'(c3rso_pkg::LINE_MAX))
        begin
            width_eff = 13'(c3rso_pkg::LINE_MAX);
        end
        else
        begin
            width_eff = cfg.width;
        end
    end

    assign fs       = in_beat.frame_start;
    assign c_now    = fs ? '0 : col_cnt_reg;
    assign r_now    = fs ? '0 : row_cnt_reg;
    assign last_now = ({1'b0, c_now} + 13'd1) >= width_eff;

    c3rso_ram #(.WIDTH(64), .DEPTH(c3rso_pkg::LINE_MAX)) u_up (
        .clk(clk), .we(cmd.win), .re(cmd.take), .addr(cmd.take ? c_now : c_reg),
        .wdata(mid_rd), .rdata(up_rd));

    c3rso_ram #(.WIDTH(64), .DEPTH(c3rso_pkg::LINE_MAX)) u_mid (
        .clk(clk), .we(cmd.win), .re(cmd.take), .addr(cmd.take ? c_now : c_reg),
        .wdata(pix_reg), .rdata(mid_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            out_full <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (last_now)
                begin
                    col_cnt_reg <= '0;
                    if (r_now != 13'd8191)
                    begin
                        row_cnt_reg <= r_now + 13'd1;
                    end
                    else
                    begin
                        row_cnt_reg <= r_now;
                    end
                end
                else
                begin
                    col_cnt_reg <= c_now + AW'(1);
                    row_cnt_reg <= r_now;
                end
            end
            if (cmd.win)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= up_rd;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid_rd;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= pix_reg;
            end
            if (cmd.out_load)
            begin
                out_full <= 1'b1;
            end
            else if (out_taken)
            begin
                out_full <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg  <= {c3rso_pkg::trunc_mask(in_beat.pix_alpha, cfg.deep),
                         c3rso_pkg::trunc_mask(in_beat.pix_blue, cfg.deep),
                         c3rso_pkg::trunc_mask(in_beat.pix_green, cfg.deep),
                         c3rso_pkg::trunc_mask(in_beat.pix_red, cfg.deep)};
            c_reg    <= c_now;
            r_reg    <= r_now;
            last_reg <= last_now;
        end
        if (cmd.win)
        begin
            col_reg[0][0] <= win_reg[0];
            col_reg[0][1] <= win_reg[1];
            col_reg[0][2] <= up_rd;
            col_reg[1][0] <= win_reg[2];
            col_reg[1][1] <= win_reg[3];
            col_reg[1][2] <= mid_rd;
            col_reg[2][0] <= win_reg[4];
            col_reg[2][1] <= win_reg[5];
            col_reg[2][2] <= pix_reg;
            emit_reg      <= (r_reg >= 13'd2) && (c_reg >= AW'(2));
        end
        if (cmd.mac)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= chan_sum(k);
            end
        end
        if (cmd.fin)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= sum_reg[k] * cfg.scale;
            end
        end
        if (cmd.out_load)
        begin
            out_beat.res_alpha   <= col_reg[1][1][63:48];
            out_beat.write_pixel <= (col_reg[1][1][63:48] != 16'd0);
            out_beat.row_end     <= last_reg;
            if (col_reg[1][1][63:48] == 16'd0)
            begin
                out_beat.res_red   <= '0;
                out_beat.res_green <= '0;
                out_beat.res_blue  <= '0;
            end
            else if (cfg.gray)
            begin
                out_beat.res_red   <= gray_c;
                out_beat.res_green <= gray_c;
                out_beat.res_blue  <= gray_c;
            end
            else
            begin
                out_beat.res_red   <= res_c[0];
                out_beat.res_green <= res_c[1];
                out_beat.res_blue  <= res_c[2];
            end
        end
    end

    assign emit = emit_reg;

    function automatic logic signed [7:0] wt(input logic [23:0] rowreg, input int p);
        case (p)
            0:       wt = rowreg[7:0];
            1:       wt = rowreg[23:16];
            default: wt = rowreg[15:8];
        endcase
    endfunction

    // nine 8x17 products per channel, narrow adder tree
    function automatic logic signed [27:0] chan_sum(input int k);
        logic signed [27:0] acc;
        logic [23:0]        rw;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            rw = (i == 0) ? cfg.coef_top : ((i == 1) ? cfg.coef_mid : cfg.coef_bot);
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + 28'(wt(rw, j) * $signed({1'b0, col_reg[i][j][16*k +: 16]}));
            end
        end
        chan_sum = acc;
    endfunction

    // offset, truncate, clamp
    always_comb
    begin
        logic signed [52:0] tot;
        logic [36:0]        q;
        logic [15:0]        lim;
        lim = cfg.deep ? 16'(c3rso_pkg::MAX16) : 16'd255;
        for (int k = 0; k < 3; k++)
        begin
            tot = 53'(prod_reg[k]) + 53'($signed({cfg.offset, 16'd0}));
            q   = tot[52:16];
            if (tot < 0)
            begin
                res_c[k] = '0;
            end
            else if (q > 37'(lim))
            begin
                res_c[k] = lim;
            end
            else
            begin
                res_c[k] = q[15:0];
            end
        end
    end

    always_comb
    begin
        logic [25:0] l;
        l = 26'(res_c[0]) * 26'd77 + 26'(res_c[1]) * 26'd150 + 26'(res_c[2]) * 26'd29;
        gray_c = l[23:8];
    end

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_cnt_reg} < width_eff || $past(cfg.width) != cfg.width
        || !$past(cmd.take))
        else $error("column count past width");
    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full && !out_taken && !cmd.out_load) |=> out_full)
        else $error("result dropped");
    a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(row_cnt_reg) == 13'd8191 && !$past(fs)) |-> row_cnt_reg == 13'd8191)
        else $error("row count wrapped");
`endif

endmodule

/* hw/rtl/conv3x3_rgb_scale_offset.sv */
// ---------------------------------------------------------------------------
// conv3x3_rgb_scale_offset
// 3x3 rgb convolution with q8.16 scale, offset and clamp on a padded frame
// ---------------------------------------------------------------------------
//  channel   signals                            direction
//  in        in_valid / in_ready / in_data      input beat (one padded pixel)
//  out       out_valid / out_ready / out_data   result beat (interior pixel)
//  cfg       cfg_we / cfg_index / cfg_data      register write, no wait
//
// the sequencer steps each pixel through store read and window and, when a
// result is due, sum, scale multiply and output load.
// rst_n clears counters, window and output flag; line stores are not cleared.
// a full output register stalls the sequencer before the output load only.
module conv3x3_rgb_scale_offset (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  c3rso_pkg::in_beat_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output c3rso_pkg::out_beat_t           out_data,
    input  logic                           cfg_we,
    input  logic [c3rso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c3rso_pkg::CFG_W-1:0]    cfg_data
);

    c3rso_pkg::cfg_t    cfg_reg;
    c3rso_pkg::dp_cmd_t cmd;
    logic               emit;
    logic               out_full;
    logic               out_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_top <= 24'd0;
            cfg_reg.coef_mid <= 24'd65536;
            cfg_reg.coef_bot <= 24'd0;
            cfg_reg.scale    <= 24'sd65536;
            cfg_reg.offset   <= '0;
            cfg_reg.gray     <= 1'b0;
            cfg_reg.deep     <= 1'b0;
            cfg_reg.width    <= 13'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                c3rso_pkg::REG_COEF_TOP: cfg_reg.coef_top <= cfg_data;
                c3rso_pkg::REG_COEF_MID: cfg_reg.coef_mid <= cfg_data;
                c3rso_pkg::REG_COEF_BOT: cfg_reg.coef_bot <= cfg_data;
                c3rso_pkg::REG_SCALE:    cfg_reg.scale    <= cfg_data;
                c3rso_pkg::REG_OFFSET:   cfg_reg.offset   <= cfg_data[16:0];
                c3rso_pkg::REG_GRAY:     cfg_reg.gray     <= cfg_data[0];
                c3rso_pkg::REG_DEEP:     cfg_reg.deep     <= cfg_data[0];
                c3rso_pkg::REG_WIDTH:    cfg_reg.width    <= cfg_data[12:0];
                default:                 cfg_reg.width    <= cfg_reg.width;
            endcase
        end
    end

    assign out_valid = out_full;
    assign out_taken = out_full && out_ready;

    c3rso_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .emit(emit), .out_full(out_full), .out_taken(out_taken), .cmd(cmd));

    c3rso_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .in_beat(in_data), .cmd(cmd),
        .emit(emit), .out_full(out_full), .out_taken(out_taken), .out_beat(out_data));

endmodule
